// ===== rtl/ps2prb_pkg.sv =====
// ----------------------------------------------------------------------------
// ps2prb_pkg
// Types and constants shared by the keyboard/mouse port register block:
// action codes, register numbers, status and control bits, the ID table.
// ----------------------------------------------------------------------------
package ps2prb_pkg;

    // Kind of item presented on the slave side
    typedef enum logic [1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_LEVEL = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    localparam int OFFSET_W  = 12;
    localparam int REG_NUM_W = OFFSET_W - 2;

    // Register numbers (byte offset >> 2)
    localparam logic [REG_NUM_W-1:0] REG_CONTROL = 10'd0;
    localparam logic [REG_NUM_W-1:0] REG_STATUS  = 10'd1;
    localparam logic [REG_NUM_W-1:0] REG_DATA    = 10'd2;
    localparam logic [REG_NUM_W-1:0] REG_CLKDIV  = 10'd3;
    localparam logic [REG_NUM_W-1:0] REG_IRQ     = 10'd4;

    // Start of the read-only ID window
    localparam logic [OFFSET_W-1:0] ID_BASE = 12'hFE0;

    // Status bits
    localparam logic [31:0] ST_TXEMPTY  = 32'h0000_0040;
    localparam logic [31:0] ST_RXFULL   = 32'h0000_0010;
    localparam logic [31:0] ST_RXPARITY = 32'h0000_0004;

    // Interrupt status: transmit interrupt always shown
    localparam logic [31:0] IRQ_ST_TX = 32'h0000_0002;

    // Control word bit positions
    localparam int CR_RXIRQ_EN  = 4;
    localparam int CR_FORCE_IRQ = 3;

    // One input item
    typedef struct packed {
        t_action        action;
        logic [11:0]    offset;
        logic [31:0]    write_data;
        logic           ready_level;
        logic [7:0]     rx_byte;
    } t_item;

    // One result item
    typedef struct packed {
        logic [31:0]    read_data;
        logic           irq_out;
        logic           tx_valid;
        logic [7:0]     tx_byte;
        logic           rx_taken;
        logic           bad_offset;
    } t_result;

    // Fixed identification bytes
    function automatic logic [7:0] id_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h50;
            3'd1:    b = 8'h10;
            3'd2:    b = 8'h04;
            3'd3:    b = 8'h00;
            3'd4:    b = 8'h0D;
            3'd5:    b = 8'hF0;
            3'd6:    b = 8'h05;
            3'd7:    b = 8'hB1;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/ps2prb_regs.sv =====
// ----------------------------------------------------------------------------
// ps2prb_regs
// Register file and access decode: holds control, divisor, last received
// byte and the pending flag, and forms the result of one item.
// ----------------------------------------------------------------------------
module ps2prb_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  ps2prb_pkg::t_item   i_item,
    output ps2prb_pkg::t_result o_result
);
    import ps2prb_pkg::*;

    logic [31:0]          r_control;
    logic [31:0]          r_clkdiv;
    logic [7:0]           r_last_rx;
    logic                 r_pending;
    logic [31:0]          n_control;
    logic [31:0]          n_clkdiv;
    logic [7:0]           n_last_rx;
    logic                 n_pending;
    logic [REG_NUM_W-1:0] reg_num;
    t_result              res;

    assign reg_num = i_item.offset[OFFSET_W-1:2];

    // Access decode and next state
    always_comb begin
        n_control = r_control;
        n_clkdiv  = r_clkdiv;
        n_last_rx = r_last_rx;
        n_pending = r_pending;
        res       = '0;
        case (i_item.action)
            ACT_READ: begin
                if (i_item.offset >= ID_BASE) begin
                    res.read_data = {24'd0, id_byte(i_item.offset[4:2])};
                end else begin
                    case (reg_num)
                        REG_CONTROL: res.read_data = r_control;
                        REG_STATUS: begin
                            res.read_data = ST_TXEMPTY
                                | (^r_last_rx ? ST_RXPARITY : 32'd0)
                                | (r_pending ? ST_RXFULL : 32'd0);
                        end
                        REG_DATA: begin
                            // a pending byte is latched by the read
                            if (r_pending) begin
                                n_last_rx    = i_item.rx_byte;
                                res.rx_taken = 1'b1;
                            end
                            res.read_data = {24'd0, n_last_rx};
                        end
                        REG_CLKDIV: res.read_data = r_clkdiv;
                        REG_IRQ:    res.read_data = IRQ_ST_TX | {31'd0, r_pending};
                        default:    res.bad_offset = 1'b1;
                    endcase
                end
            end
            ACT_WRITE: begin
                case (reg_num)
                    REG_CONTROL: n_control = i_item.write_data;
                    REG_DATA: begin
                        res.tx_valid = 1'b1;
                        res.tx_byte  = i_item.write_data[7:0];
                    end
                    REG_CLKDIV: n_clkdiv = i_item.write_data;
                    default:    res.bad_offset = 1'b1;
                endcase
            end
            ACT_LEVEL: n_pending = i_item.ready_level;
            default: ;
        endcase
        // interrupt level after the item
        res.irq_out = (n_pending & n_control[CR_RXIRQ_EN]) | n_control[CR_FORCE_IRQ];
    end

    assign o_result = res;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_control <= '0;
            r_clkdiv  <= '0;
            r_last_rx <= '0;
            r_pending <= 1'b0;
        end else if (i_fire) begin
            r_control <= n_control;
            r_clkdiv  <= n_clkdiv;
            r_last_rx <= n_last_rx;
            r_pending <= n_pending;
        end
    end

endmodule

// ===== rtl/ps2_port_register_block.sv =====
// ----------------------------------------------------------------------------
// ps2_port_register_block
// Keyboard/mouse serial port register block with a streaming item interface.
// ----------------------------------------------------------------------------
// Each slave-side item (bus read, bus write, receive-ready level change or
// no action) gives exactly one master-side result item. Items pass through
// an input register, one decode step against the register file, and a
// result register, which presents the result once the decode step has run;
// one item per clock is sustained while the master side takes results,
// set by the single decode step that updates the register state. The input
// register keeps taking items while a result waits, until both registers
// are full. The device kind register is written through i_cfg_we and
// i_cfg_wdata, by the user only while the block is idle; the block itself
// does not enforce this. The register does not change any result.
module ps2_port_register_block (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: device kind, 1 mouse, 0 keyboard
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    // slave side
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [11:0] offset, [43:12] write_data, [44] ready_level, [52:45] rx_byte,
    // [55:53] zero
    input  logic [55:0] s_axis_tdata,
    // [1:0] action
    input  logic [1:0]  s_axis_tuser,
    // master side
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] read_data, [32] irq_out, [33] tx_valid, [41:34] tx_byte,
    // [42] rx_taken, [43] bad_offset, [47:44] zero
    output logic [47:0] m_axis_tdata
);
    import ps2prb_pkg::*;

    logic    r_device_is_mouse;
    logic    r_in_valid;
    t_item   r_in_item;
    logic    r_out_valid;
    t_result r_out_result;
    t_result result;
    logic    advance;

    // Item moves from input register to result register
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    // Device kind register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_is_mouse <= 1'b0;
        end else if (i_cfg_we) begin
            r_device_is_mouse <= i_cfg_wdata;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_item.action      <= t_action'(s_axis_tuser);
            r_in_item.offset      <= s_axis_tdata[11:0];
            r_in_item.write_data  <= s_axis_tdata[43:12];
            r_in_item.ready_level <= s_axis_tdata[44];
            r_in_item.rx_byte     <= s_axis_tdata[52:45];
        end
    end

    // Register file and decode
    ps2prb_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_in_item),
        .o_result (result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_result <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0,
                            r_out_result.bad_offset,
                            r_out_result.rx_taken,
                            r_out_result.tx_byte,
                            r_out_result.tx_valid,
                            r_out_result.irq_out,
                            r_out_result.read_data};

`ifndef SYNTHESIS
    // a byte sent to the device never comes with read data or a bad offset
    a_tx_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_out_result.tx_valid) |->
            (r_out_result.read_data == 32'd0 && !r_out_result.bad_offset
             && !r_out_result.rx_taken))
        else $error("tx result carries read fields");

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!m_axis_tvalid && !r_in_valid))
        else $error("item registers not cleared by reset");

    // both registers full and master stalled: no new item taken
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("item accepted while pipeline full");

    // device kind follows the last configuration write
    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_device_is_mouse == $past(i_cfg_wdata)))
        else $error("device kind register not written");
`endif

endmodule
